// File: hdl/fircb_pkg.sv
// Shared types and constants for the circular-buffer FIR filter.
// Used by the front, queue, back and top-level modules; no dependencies.
package fircb_pkg;

  // Field widths fixed by the item format
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int IDX_W     = 6;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS = 14;

  // Rounding bias: half an LSB upward for positive sums, just under half
  // for negative sums, so an arithmetic shift rounds half away from zero
  localparam int ROUND_POS = 8192;
  localparam int ROUND_NEG = 8191;

  // Saturation limits of the 16-bit result
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Function codes on the input item
  typedef enum logic [1:0] {
    FUNC_FILTER = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  // Commands that reach the back end after classification
  typedef enum logic [1:0] {
    OP_FILTER,
    OP_COEF,
    OP_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                    op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } cmd_t;

  // Back-end states
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MAC,
    ST_ROUND
  } back_state_t;

  // Status reported by the back end to the front end
  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

// File: hdl/fircb_front.sv
// Front end: accepts input items, drops ignored ones, and forms commands.
// Depends on fircb_pkg.
module fircb_front #(
  parameter int TAPS = 63
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          func,
  input  logic signed [fircb_pkg::SAMPLE_W-1:0] sample,
  input  logic [fircb_pkg::IDX_W-1:0]         coef_index,
  input  logic signed [fircb_pkg::COEF_W-1:0] coef_value,
  input  fircb_pkg::back_status_t             status,
  output logic                                push,
  output fircb_pkg::cmd_t                     push_cmd,
  input  logic                                push_ready
);
  import fircb_pkg::*;

  logic   front_valid;
  cmd_t   front_cmd;
  logic   accept;
  logic   keep;
  cmd_t   cmd_in;

  // Classify the incoming item
  always_comb begin
    cmd_in.sample     = sample;
    cmd_in.coef_index = coef_index;
    cmd_in.coef_value = coef_value;
    cmd_in.op         = OP_FILTER;
    keep              = 1'b0;
    case (func)
      FUNC_FILTER: begin
        cmd_in.op = OP_FILTER;
        keep      = 1'b1;
      end
      FUNC_COEF: begin
        cmd_in.op = OP_COEF;
        keep      = (32'(coef_index) < TAPS);
      end
      FUNC_CLEAR: begin
        cmd_in.op = OP_CLEAR;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Hold off while both memories are cleared after reset or the held command cannot move
  assign in_stall = status.init_busy || (front_valid && !push_ready);
  assign accept   = in_valid && !in_stall;
  assign push     = front_valid && push_ready;
  assign push_cmd = front_cmd;

  // Hold one classified item; drop the ignored ones
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= keep;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd <= cmd_in;
    end
  end

endmodule

// File: hdl/fircb_queue.sv
// Short command queue between the front end and the back end.
// Depends on fircb_pkg.
module fircb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fircb_pkg::cmd_t push_cmd,
  output logic            push_ready,
  output logic            pop_valid,
  output fircb_pkg::cmd_t pop_cmd,
  input  logic            pop
);
  import fircb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hdl/fircb_back.sv
// Back end: history ring and coefficient memories, a shared multiply-accumulate
// that walks the taps, rounding, saturation and the output register.
// Depends on fircb_pkg.
module fircb_back #(
  parameter int TAPS          = 63,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pop_valid,
  input  fircb_pkg::cmd_t                      pop_cmd,
  output logic                                 pop,
  output fircb_pkg::back_status_t              status,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fircb_pkg::SAMPLE_W-1:0] filtered,
  output logic                                 clipped
);
  import fircb_pkg::*;

  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int COEF_AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TAP_W   = $clog2(TAPS + 1);
  localparam int SWEEP_N = (TAPS > HISTORY_DEPTH) ? TAPS : HISTORY_DEPTH;
  localparam int SWEEP_W = $clog2(SWEEP_N);
  localparam int ACC_W   = PROD_W + $clog2(TAPS) + 1;

  // Memories
  logic signed [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
  logic signed [COEF_W-1:0]   coef_mem [TAPS];

  back_state_t                state;
  back_state_t                state_next;
  logic                       sweep_coef;
  logic [SWEEP_W-1:0]         sweep_cnt;
  logic [HIST_AW-1:0]         wp;
  logic [HIST_AW-1:0]         wp_inc;
  logic [HIST_AW-1:0]         rd_ptr;
  logic [TAP_W-1:0]           tap_cnt;
  logic                       s1;
  logic                       s2;
  logic signed [COEF_W-1:0]   coef_q;
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  // Combinational control
  logic                       issue;
  logic                       sweep_last;
  logic                       mac_done;
  logic                       out_free;
  logic                       hist_we;
  logic [HIST_AW-1:0]         hist_waddr;
  logic signed [SAMPLE_W-1:0] hist_wdata;
  logic                       coef_we;
  logic [COEF_AW-1:0]         coef_waddr;
  logic signed [COEF_W-1:0]   coef_wdata;
  logic signed [ACC_W-1:0]    biased;
  logic signed [ACC_W-1:0]    rounded;
  logic                       sat_hi;
  logic                       sat_lo;

  assign wp_inc     = (wp == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign issue      = (state == ST_MAC) && (tap_cnt != TAP_W'(TAPS));
  assign mac_done   = (state == ST_MAC) && (tap_cnt == TAP_W'(TAPS)) && !s1 && !s2;
  assign sweep_last = sweep_coef ? (sweep_cnt == SWEEP_W'(SWEEP_N - 1))
                                 : (sweep_cnt == SWEEP_W'(HISTORY_DEPTH - 1));
  assign out_free   = !out_valid || !out_stall;
  assign status.init_busy = (state == ST_SWEEP) && sweep_coef;

  // Round half away from zero, then saturate
  assign biased  = acc + (acc[ACC_W-1] ? ACC_W'(ROUND_NEG) : ACC_W'(ROUND_POS));
  assign rounded = biased >>> FRAC_BITS;
  assign sat_hi  = (rounded > ACC_W'(SAT_MAX));
  assign sat_lo  = (rounded < ACC_W'(SAT_MIN));

  // Next state and memory write controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    hist_we    = 1'b0;
    hist_waddr = wp_inc;
    hist_wdata = pop_cmd.sample;
    coef_we    = 1'b0;
    coef_waddr = COEF_AW'(pop_cmd.coef_index);
    coef_wdata = pop_cmd.coef_value;
    case (state)
      ST_SWEEP: begin
        hist_waddr = sweep_cnt[HIST_AW-1:0];
        hist_wdata = '0;
        hist_we    = (32'(sweep_cnt) < HISTORY_DEPTH);
        coef_waddr = sweep_cnt[COEF_AW-1:0];
        coef_wdata = '0;
        coef_we    = sweep_coef && (32'(sweep_cnt) < TAPS);
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid) begin
          pop = 1'b1;
          case (pop_cmd.op)
            OP_FILTER: begin
              hist_we    = 1'b1;
              state_next = ST_MAC;
            end
            OP_COEF: begin
              coef_we = 1'b1;
            end
            OP_CLEAR: begin
              state_next = ST_SWEEP;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_coef <= 1'b1;
      sweep_cnt  <= '0;
      wp         <= '0;
      tap_cnt    <= '0;
      s1         <= 1'b0;
      s2         <= 1'b0;
    end else begin
      state <= state_next;
      s1    <= issue;
      s2    <= s1;
      if (state == ST_SWEEP) begin
        if (sweep_last) begin
          sweep_coef <= 1'b0;
          sweep_cnt  <= '0;
        end else begin
          sweep_cnt <= sweep_cnt + 1'b1;
        end
      end
      if (pop && (pop_cmd.op == OP_FILTER)) begin
        wp      <= wp_inc;
        tap_cnt <= '0;
      end else if (pop && (pop_cmd.op == OP_CLEAR)) begin
        wp <= '0;
      end else if (issue) begin
        tap_cnt <= tap_cnt + 1'b1;
      end
    end
  end

  // Walk the ring backwards; accumulate the products
  always_ff @(posedge clk) begin
    if (pop && (pop_cmd.op == OP_FILTER)) begin
      rd_ptr <= wp_inc;
      acc    <= '0;
    end else begin
      if (issue) begin
        rd_ptr <= (rd_ptr == '0) ? HIST_AW'(HISTORY_DEPTH - 1) : rd_ptr - 1'b1;
      end
      if (s2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    prod <= coef_q * hist_q;
  end

  // History memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (issue) begin
      hist_q <= hist_mem[rd_ptr];
    end
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    if (issue) begin
      coef_q <= coef_mem[tap_cnt[COEF_AW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_ROUND) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_ROUND) && out_free) begin
      clipped <= sat_hi || sat_lo;
      if (sat_hi) begin
        filtered <= SAMPLE_W'(SAT_MAX);
      end else if (sat_lo) begin
        filtered <= SAMPLE_W'(SAT_MIN);
      end else begin
        filtered <= rounded[SAMPLE_W-1:0];
      end
    end
  end

endmodule

// File: hdl/fir_filter_circular_buffer_top.sv
// Channel | Handshake           | Payload
// in      | in_valid / in_stall | func, sample, coef_index, coef_value
// out     | out_valid / out_stall | filtered, clipped
//
// A filter item holds the back end through the pop, one coefficient and one
// history read per cycle into a shared multiply-accumulate, the drain of its
// pipeline, and a rounding state that waits while a held result is stalled.
// A coefficient is written as it is popped; a clear zeroes the history memory
// only. After reset both memories are cleared, and in_stall stays high until
// that is done. A two-entry queue lets the front keep accepting while the back
// works, and the output register holds a result under out_stall.
// Top level of the circular-buffer FIR filter; depends on fircb_pkg and the
// front, queue and back modules.
module fir_filter_circular_buffer_top #(
  parameter int TAPS          = 63,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            func,
  input  logic signed [fircb_pkg::SAMPLE_W-1:0] sample,
  input  logic [fircb_pkg::IDX_W-1:0]           coef_index,
  input  logic signed [fircb_pkg::COEF_W-1:0]   coef_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fircb_pkg::SAMPLE_W-1:0] filtered,
  output logic                                  clipped
);
  import fircb_pkg::*;

  logic         push;
  cmd_t         push_cmd;
  logic         push_ready;
  logic         pop_valid;
  cmd_t         pop_cmd;
  logic         pop;
  back_status_t status;

  fircb_front #(
    .TAPS(TAPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .sample    (sample),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .status    (status),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_ready(push_ready)
  );

  fircb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop)
  );

  fircb_back #(
    .TAPS         (TAPS),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered (filtered),
    .clipped  (clipped)
  );

endmodule

// File: hdl/fircb_checker.sv
// Port-level checks for the circular-buffer FIR filter, bound to the top level.
// Depends on fircb_pkg.
module fircb_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic [1:0]                            func,
  input logic signed [fircb_pkg::SAMPLE_W-1:0] sample,
  input logic [fircb_pkg::IDX_W-1:0]           coef_index,
  input logic signed [fircb_pkg::COEF_W-1:0]   coef_value,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [fircb_pkg::SAMPLE_W-1:0] filtered,
  input logic                                  clipped
);
  import fircb_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(filtered) && $stable(clipped))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // Memories are being cleared after reset; no item is taken
  a_reset_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("item accepted during the clearing pass");

  // A clipped result sits at one of the saturation limits
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (filtered == SAMPLE_W'(SAT_MAX)) || (filtered == SAMPLE_W'(SAT_MIN)))
    else $error("clipped result not at a limit");

endmodule

bind fir_filter_circular_buffer_top fircb_checker u_fircb_checker (.*);
